// ===== design/tean_pkg.sv =====
// Shared types and constants for the TEAN block cipher pipeline.
`timescale 1ns / 1ps

package tean_pkg;

  localparam logic [31:0] TEAN_DELTA = 32'h9e3779b9;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned KEY_IDX_W = 2;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef logic [31:0] tean_word_t;
  typedef tean_word_t [KEY_WORDS-1:0] tean_key_t;

  typedef struct packed {
    logic       opcode;
    tean_word_t left;
    tean_word_t right;
  } tean_data_t;

endpackage

// ===== design/tean_if.sv =====
// Valid/ready channel interfaces for TEAN input blocks and results.
`timescale 1ns / 1ps

interface tean_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] block_left;
  logic [31:0] block_right;

  modport source (output valid, output opcode, output block_left, output block_right,
                  input ready);
  modport sink (input valid, input opcode, input block_left, input block_right,
                output ready);
endinterface

interface tean_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_left;
  logic [31:0] result_right;

  modport source (output valid, output result_left, output result_right, input ready);
  modport sink (input valid, input result_left, input result_right, output ready);
endinterface

// ===== design/tean_cell.sv =====
// One TEAN half-round cell: mixes one half into the other and holds the beat.
`timescale 1ns / 1ps

module tean_cell
  import tean_pkg::*;
#(
  parameter bit          UPD_LEFT_ENC = 1'b1,
  parameter logic [31:0] SUM_ENC      = 32'h0,
  parameter logic [31:0] SUM_DEC      = 32'h0,
  parameter logic [1:0]  KIDX_ENC     = 2'd0,
  parameter logic [1:0]  KIDX_DEC     = 2'd0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  tean_key_t  key,
  input  logic       up_valid,
  output logic       up_ready,
  input  tean_data_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output tean_data_t dn_data
);

  logic       valid_r;
  logic       valid_nxt;
  tean_data_t data_r;
  tean_data_t data_nxt;

  logic       dec;
  logic       upd_left;
  tean_word_t src;
  tean_word_t tgt;
  tean_word_t sum;
  tean_word_t kw;
  tean_word_t mix;
  tean_word_t tgt_nxt;

  assign dec      = (up_data.opcode == OP_DECRYPT);
  assign upd_left = dec ? !UPD_LEFT_ENC : UPD_LEFT_ENC;
  assign src      = upd_left ? up_data.right : up_data.left;
  assign tgt      = upd_left ? up_data.left : up_data.right;
  assign sum      = dec ? SUM_DEC : SUM_ENC;
  assign kw       = dec ? key[KIDX_DEC] : key[KIDX_ENC];
  assign mix      = ((src << 4) ^ (src >> 5)) + (src ^ sum) + kw;
  assign tgt_nxt  = dec ? (tgt - mix) : (tgt + mix);

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    data_nxt = up_data;
    if (upd_left) begin
      data_nxt.left = tgt_nxt;
    end else begin
      data_nxt.right = tgt_nxt;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== design/tean_block_cipher.sv =====
// Top level of the TEAN block cipher: key registers and the chain of half-round cells.
//
//   channel  dir  beat contents
//   in_ch    in   opcode, block_left, block_right
//   out_ch   out  result_left, result_right
//   cfg      in   cfg_wr_en, cfg_index, cfg_wdata (key word write)
//
// One block enters per cycle when nothing stalls; each passes 2*ROUNDS half-round
// cells, and each cell registers the beat before passing it on to the next.
// Each cell holds one beat and passes it on when its neighbor has room, so gaps
// close up and input is taken while a result waits at the output.
// Reset clears all cell valid bits and the key words to zero.
`timescale 1ns / 1ps

module tean_block_cipher
  import tean_pkg::*;
#(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tean_in_if.sink              in_ch,
  tean_out_if.source           out_ch,
  input  logic                 cfg_wr_en,
  input  logic [KEY_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  localparam int unsigned STAGES = 2 * ROUNDS;

  tean_key_t key_r;

  logic       vld [STAGES+1];
  logic       rdy [STAGES+1];
  tean_data_t dat [STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_wr_en) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  assign vld[0]         = in_ch.valid;
  assign in_ch.ready    = rdy[0];
  assign dat[0]         = {in_ch.opcode, in_ch.block_left, in_ch.block_right};

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam logic [31:0] SUM_E0 = 32'(TEAN_DELTA * 32'(r));
    localparam logic [31:0] SUM_E1 = 32'(TEAN_DELTA * 32'(r + 1));
    localparam logic [31:0] SUM_D0 = 32'(TEAN_DELTA * 32'(ROUNDS - r));
    localparam logic [31:0] SUM_D1 = 32'(TEAN_DELTA * 32'(ROUNDS - r - 1));

    tean_cell #(
      .UPD_LEFT_ENC (1'b1),
      .SUM_ENC      (SUM_E0),
      .SUM_DEC      (SUM_D0),
      .KIDX_ENC     (SUM_E0[1:0]),
      .KIDX_DEC     (SUM_D0[12:11])
    ) u_cell_a (
      .clk      (clk),
      .rst_n    (rst_n),
      .key      (key_r),
      .up_valid (vld[2*r]),
      .up_ready (rdy[2*r]),
      .up_data  (dat[2*r]),
      .dn_valid (vld[2*r+1]),
      .dn_ready (rdy[2*r+1]),
      .dn_data  (dat[2*r+1])
    );

    tean_cell #(
      .UPD_LEFT_ENC (1'b0),
      .SUM_ENC      (SUM_E1),
      .SUM_DEC      (SUM_D1),
      .KIDX_ENC     (SUM_E1[12:11]),
      .KIDX_DEC     (SUM_D1[1:0])
    ) u_cell_b (
      .clk      (clk),
      .rst_n    (rst_n),
      .key      (key_r),
      .up_valid (vld[2*r+1]),
      .up_ready (rdy[2*r+1]),
      .up_data  (dat[2*r+1]),
      .dn_valid (vld[2*r+2]),
      .dn_ready (rdy[2*r+2]),
      .dn_data  (dat[2*r+2])
    );
  end

  assign out_ch.valid        = vld[STAGES];
  assign rdy[STAGES]         = out_ch.ready;
  assign out_ch.result_left  = dat[STAGES].left;
  assign out_ch.result_right = dat[STAGES].right;

  a_ready_when_first_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !vld[1] |-> in_ch.ready)
    else $error("input stalled with first cell empty");

  a_ready_passes_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("output ready did not reach the input");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result beat present right after reset");

endmodule

// ===== tb/tean_block_cipher_tb.sv =====
// Self-checking testbench for the TEAN block cipher pipeline.
`timescale 1ns / 1ps

module tean_block_cipher_tb;
  import tean_pkg::*;

  localparam int unsigned ROUNDS = 32;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_BLOCKS = 190;

  typedef struct packed {
    tean_word_t left;
    tean_word_t right;
  } half_pair_t;

  class cipher_book;
    tean_key_t key_copy;
    half_pair_t expected_q[$];
    int unsigned mismatches;

    function new();
      key_copy = '0;
      mismatches = 0;
    endfunction

    function tean_word_t mix_half(tean_word_t x, tean_word_t s, tean_word_t k);
      tean_word_t shifted;
      shifted = (x << 4) ^ (x >> 5);
      return shifted + (x ^ s) + k;
    endfunction

    function half_pair_t run_rounds(logic op, tean_word_t y, tean_word_t z);
      tean_word_t s;
      half_pair_t res;
      int r;
      if (op == OP_ENCRYPT) begin
        s = '0;
        for (r = 0; r < ROUNDS; r++) begin
          y = y + mix_half(z, s, key_copy[s[1:0]]);
          s = s + TEAN_DELTA;
          z = z + mix_half(y, s, key_copy[s[12:11]]);
        end
      end else begin
        s = TEAN_DELTA * ROUNDS;
        for (r = 0; r < ROUNDS; r++) begin
          z = z - mix_half(y, s, key_copy[s[12:11]]);
          s = s - TEAN_DELTA;
          y = y - mix_half(z, s, key_copy[s[1:0]]);
        end
      end
      res.left = y;
      res.right = z;
      return res;
    endfunction

    function void note_block(logic op, tean_word_t l, tean_word_t r);
      expected_q.push_back(run_rounds(op, l, r));
    endfunction

    function void check_result(tean_word_t l, tean_word_t r);
      half_pair_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h %h", $time, l, r);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (want.left !== l) begin
        $display("%0t: result_left expected %h actual %h", $time, want.left, l);
        mismatches++;
      end
      if (want.right !== r) begin
        $display("%0t: result_right expected %h actual %h", $time, want.right, r);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [KEY_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  tean_in_if in_ch ();
  tean_out_if out_ch ();

  tean_block_cipher #(
    .ROUNDS(ROUNDS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  cipher_book book;
  bit tx_free;
  bit rx_free;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin : result_sink
    int unsigned rx_hold;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        book.check_result(out_ch.result_left, out_ch.result_right);
        rx_hold = rx_free ? 0 : $urandom_range(0, 7);
      end
      if (rx_hold != 0) begin
        out_ch.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_block(logic op, tean_word_t l, tean_word_t r);
    int unsigned gap;
    gap = tx_free ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.block_left <= l;
    in_ch.block_right <= r;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    book.note_block(op, l, r);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  task automatic load_key(logic [3:0] mask, tean_key_t words);
    int i;
    for (i = 0; i < KEY_WORDS; i++) begin
      if (mask[i]) begin
        cfg_wr_en <= 1'b1;
        cfg_index <= i[KEY_IDX_W-1:0];
        cfg_wdata <= words[i];
        @(posedge clk);
        book.key_copy[i] = words[i];
      end
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic tean_word_t pick_half();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(0, 31);
      3: return ~(32'd1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  function automatic tean_word_t pick_key_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic pick_op();
    return ($urandom_range(0, 1) != 0) ? OP_DECRYPT : OP_ENCRYPT;
  endfunction

  initial begin
    int ph;
    int n;
    int k;
    logic op;
    tean_word_t l;
    tean_word_t r;
    half_pair_t pair;
    tean_key_t words;
    logic [3:0] mask;

    book = new();
    tx_free = 1'b0;
    rx_free = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_ENCRYPT;
    in_ch.block_left <= '0;
    in_ch.block_right <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // zero key straight out of reset
    send_block(OP_ENCRYPT, 32'h0, 32'h0);
    send_block(OP_DECRYPT, 32'h0, 32'h0);
    send_block(OP_ENCRYPT, 32'hffffffff, 32'hffffffff);
    send_block(OP_DECRYPT, 32'hffffffff, 32'hffffffff);
    send_block(OP_ENCRYPT, 32'h80000000, 32'h00000001);
    drain_results();

    load_key(4'hf, '1);
    send_block(OP_ENCRYPT, 32'h0, 32'h0);
    send_block(OP_DECRYPT, 32'h0, 32'h0);
    send_block(OP_ENCRYPT, 32'hffffffff, 32'hffffffff);
    send_block(OP_DECRYPT, 32'hffffffff, 32'hffffffff);
    send_block(OP_ENCRYPT, 32'h00000001, 32'h80000000);
    send_block(OP_DECRYPT, 32'h80000000, 32'h00000001);
    send_block(OP_ENCRYPT, 32'haaaaaaaa, 32'h55555555);
    send_block(OP_DECRYPT, 32'h55555555, 32'haaaaaaaa);
    drain_results();

    load_key(4'hf, {32'h76543210, 32'hfedcba98, 32'h89abcdef, 32'h01234567});
    send_block(OP_ENCRYPT, 32'h01234567, 32'h89abcdef);
    pair = book.run_rounds(OP_ENCRYPT, 32'h01234567, 32'h89abcdef);
    send_block(OP_DECRYPT, pair.left, pair.right);
    send_block(OP_ENCRYPT, 32'hffffffff, 32'h00000000);
    pair = book.run_rounds(OP_ENCRYPT, 32'hffffffff, 32'h00000000);
    send_block(OP_DECRYPT, pair.left, pair.right);
    send_block(OP_ENCRYPT, 32'h55555555, 32'haaaaaaaa);
    send_block(OP_DECRYPT, 32'haaaaaaaa, 32'h55555555);

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      tx_free = (ph == 1) || ($urandom_range(0, 3) == 0);
      rx_free = (ph == 1) || ($urandom_range(0, 3) == 0);
      for (k = 0; k < KEY_WORDS; k++) begin
        words[k] = pick_key_word();
      end
      mask = (ph == 0) ? 4'hf : 4'($urandom_range(1, 15));
      load_key(mask, words);
      for (n = 0; n < PHASE_BLOCKS; n++) begin
        // hold off the sender until the pipeline is empty
        if (ph == 4 && n == PHASE_BLOCKS / 2) begin
          drain_results();
        end
        op = pick_op();
        l = pick_half();
        r = pick_half();
        if ($urandom_range(0, 7) == 0) begin
          pair = book.run_rounds(OP_ENCRYPT, l, r);
          op = OP_DECRYPT;
          l = pair.left;
          r = pair.right;
        end
        send_block(op, l, r);
      end
    end

    drain_results();
    repeat (2 * ROUNDS + 16) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
